>>> design/dct_pkg.sv
// Shared types, widths and register codes of the dual capture tachometer.
package dct_pkg;

    localparam int CAP_W    = 16;   // capture counter width
    localparam int RELOAD_W = 16;
    localparam int TICK_W   = 20;
    localparam int PPR_W    = 8;
    localparam int FREQ_W   = 20;
    localparam int RPM_W    = 16;
    localparam int PER_W    = CAP_W + 2;          // signed corrected period
    localparam int DVS_W    = CAP_W + 1;          // positive period fits here
    localparam int QUO_W    = FREQ_W + 6;         // freq * 60 fits here
    localparam int CNT_W    = 5;

    localparam int FREQ_STEPS = TICK_W;
    localparam int RPM_STEPS  = QUO_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_PPR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_PPR = 2'd3;

    localparam logic [RELOAD_W-1:0] RELOAD_RST    = 16'd65535;
    localparam logic [TICK_W-1:0]   TICK_RATE_RST = 20'd100000;
    localparam logic [PPR_W-1:0]    MOTOR_PPR_RST = 8'd4;
    localparam logic [PPR_W-1:0]    WHEEL_PPR_RST = 8'd8;

    typedef struct packed {
        logic [CAP_W-1:0] capture_motor;
        logic [CAP_W-1:0] capture_wheel;
    } t_cap_in;

    typedef struct packed {
        logic [RPM_W-1:0] rpm_motor;
        logic [RPM_W-1:0] rpm_wheel;
    } t_rpm_out;

    // commands from the controller to both lanes
    typedef struct packed {
        logic prime;      // store first captures
        logic take;       // latch new captures
        logic load_freq;  // set up tick_rate / period
        logic load_rpm;   // set up freq * 60 / ppr
        logic step;       // one divider iteration
    } t_lane_cmd;

    // status from the top level to the controller
    typedef struct packed {
        logic in_fire;
        logic out_free;
    } t_ctrl_stat;

endpackage

>>> design/dct_lane.sv
// One channel datapath: period with wrap correction, held frequency, shared divider, rpm.
module dct_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dct_pkg::t_lane_cmd          i_cmd,
    input  logic [dct_pkg::CAP_W-1:0]   i_capture,
    input  logic [dct_pkg::RELOAD_W-1:0] i_reload,
    input  logic [dct_pkg::TICK_W-1:0]  i_tick_rate,
    input  logic [dct_pkg::PPR_W-1:0]   i_ppr,
    output logic [dct_pkg::RPM_W-1:0]   o_rpm
);
    import dct_pkg::*;

    logic [CAP_W-1:0]        r_last;
    logic [CAP_W-1:0]        r_new;
    logic [FREQ_W-1:0]       r_freq;
    logic                    r_div_on;
    logic [DVS_W-1:0]        r_rem;
    logic [QUO_W-1:0]        r_quo;
    logic [DVS_W-1:0]        r_dvs;

    logic signed [PER_W-1:0] w_period;
    logic [FREQ_W-1:0]       n_freq;
    logic [QUO_W-1:0]        w_scaled;
    logic [DVS_W:0]          w_trial;
    logic [DVS_W+1:0]        w_diff;

    always_comb begin
        if (r_new > r_last) begin
            w_period = $signed({2'b00, r_new}) - $signed({2'b00, r_last});
        end else begin
            w_period = $signed({2'b00, i_reload}) - $signed({2'b00, r_last})
                     + $signed({2'b00, r_new});
        end
    end

    // frequency for the rpm load: freq quotient, or held value if no division ran
    assign n_freq   = r_div_on ? r_quo[FREQ_W-1:0] : r_freq;
    assign w_scaled = ({{(QUO_W-FREQ_W){1'b0}}, n_freq} << 6)
                    - ({{(QUO_W-FREQ_W){1'b0}}, n_freq} << 2);

    // restoring division, one quotient bit per step
    assign w_trial = {r_rem, r_quo[QUO_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= '0;
            r_new    <= '0;
            r_freq   <= '0;
            r_div_on <= 1'b0;
        end else begin
            if (i_cmd.prime) begin
                r_last <= i_capture;
            end
            if (i_cmd.take) begin
                r_new <= i_capture;
            end
            if (i_cmd.load_freq) begin
                r_last   <= r_new;
                r_div_on <= !w_period[PER_W-1] && (w_period != '0);
                // negative period: longer than any tick rate
                if (w_period[PER_W-1]) begin
                    r_freq <= '0;
                end
            end
            if (i_cmd.load_rpm) begin
                r_freq <= n_freq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_freq) begin
            r_rem <= '0;
            r_quo <= {i_tick_rate, {(QUO_W-TICK_W){1'b0}}};
            r_dvs <= w_period[DVS_W-1:0];
        end else if (i_cmd.load_rpm) begin
            r_rem <= '0;
            r_quo <= w_scaled;
            r_dvs <= {{(DVS_W-PPR_W){1'b0}}, i_ppr};
        end else if (i_cmd.step) begin
            if (!w_diff[DVS_W+1]) begin
                r_rem <= w_diff[DVS_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DVS_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    // saturate, and treat zero pulses per revolution as full scale
    assign o_rpm = ((i_ppr == '0) || (r_quo[QUO_W-1:RPM_W] != '0))
                 ? {RPM_W{1'b1}} : r_quo[RPM_W-1:0];

endmodule

>>> design/dct_ctrl.sv
// Sequencer for priming, the frequency division and the rpm division.
module dct_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dct_pkg::t_ctrl_stat i_stat,
    output logic                o_in_ready,
    output dct_pkg::t_lane_cmd  o_cmd,
    output logic                o_result_load
);
    import dct_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FLOAD = 3'd1;
    localparam logic [2:0] ST_FSTEP = 3'd2;
    localparam logic [2:0] ST_RLOAD = 3'd3;
    localparam logic [2:0] ST_RSTEP = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_primed;
    logic             n_primed;

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_primed      = r_primed;
        o_cmd         = '0;
        o_result_load = 1'b0;
        o_in_ready    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_stat.in_fire) begin
                    if (!r_primed) begin
                        o_cmd.prime = 1'b1;
                        n_primed    = 1'b1;
                    end else begin
                        o_cmd.take = 1'b1;
                        n_state    = ST_FLOAD;
                    end
                end
            end
            ST_FLOAD: begin
                o_cmd.load_freq = 1'b1;
                n_cnt           = CNT_W'(FREQ_STEPS - 1);
                n_state         = ST_FSTEP;
            end
            ST_FSTEP: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_RLOAD;
                end
            end
            ST_RLOAD: begin
                o_cmd.load_rpm = 1'b1;
                n_cnt          = CNT_W'(RPM_STEPS - 1);
                n_state        = ST_RSTEP;
            end
            ST_RSTEP: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register has room
                if (i_stat.out_free) begin
                    o_result_load = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_primed <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_primed <= n_primed;
        end
    end

endmodule

>>> design/dual_capture_tachometer.sv
// Top level: configuration registers, two channel lanes, controller, output register.
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_in_data  (t_cap_in)
//  out     | output    | o_out_valid / i_out_ready | o_out_data (t_rpm_out)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// The first transaction after reset only stores the captures; the block stays ready.
// Every later one runs through the per-lane restoring divider, a load and 20 steps for
// frequency, then a load and 26 steps for rpm, and its result is written to the output
// register once that has room; no further transaction is taken before then.
// Both channels run side by side; the next transaction is taken once the result is stored.
// A result waiting on o_out_valid does not block input until the next result is ready.
// Reset is synchronous; configuration writes are always taken.
module dual_capture_tachometer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  dct_pkg::t_cap_in              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output dct_pkg::t_rpm_out             o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dct_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dct_pkg::*;

    logic [RELOAD_W-1:0] r_reload;
    logic [TICK_W-1:0]   r_tick_rate;
    logic [PPR_W-1:0]    r_motor_ppr;
    logic [PPR_W-1:0]    r_wheel_ppr;
    logic                r_out_valid;
    t_rpm_out            r_out_data;

    t_lane_cmd           w_cmd;
    t_ctrl_stat          w_stat;
    logic                w_res_load;
    logic [RPM_W-1:0]    w_rpm_motor;
    logic [RPM_W-1:0]    w_rpm_wheel;

    assign o_cfg_ready     = 1'b1;
    assign w_stat.in_fire  = i_in_valid && o_in_ready;
    assign w_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload    <= RELOAD_RST;
            r_tick_rate <= TICK_RATE_RST;
            r_motor_ppr <= MOTOR_PPR_RST;
            r_wheel_ppr <= WHEEL_PPR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RELOAD:    r_reload    <= i_cfg_data[RELOAD_W-1:0];
                CFG_TICK_RATE: r_tick_rate <= i_cfg_data[TICK_W-1:0];
                CFG_MOTOR_PPR: r_motor_ppr <= i_cfg_data[PPR_W-1:0];
                CFG_WHEEL_PPR: r_wheel_ppr <= i_cfg_data[PPR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dct_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stat        (w_stat),
        .o_in_ready    (o_in_ready),
        .o_cmd         (w_cmd),
        .o_result_load (w_res_load)
    );

    dct_lane u_motor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_capture   (i_in_data.capture_motor),
        .i_reload    (r_reload),
        .i_tick_rate (r_tick_rate),
        .i_ppr       (r_motor_ppr),
        .o_rpm       (w_rpm_motor)
    );

    dct_lane u_wheel (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_capture   (i_in_data.capture_wheel),
        .i_reload    (r_reload),
        .i_tick_rate (r_tick_rate),
        .i_ppr       (r_wheel_ppr),
        .o_rpm       (w_rpm_wheel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out_data.rpm_motor <= w_rpm_motor;
            r_out_data.rpm_wheel <= w_rpm_wheel;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending transaction");

    // after a result is stored the block is free for the next transaction
    a_load_then_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_load |=> (o_in_ready && o_out_valid))
        else $error("not idle with valid output after result load");

    // no result can follow an accepted transaction in the next cycle
    a_accept_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !w_res_load)
        else $error("result loaded right after an accepted transaction");

endmodule
